### design/aac_superframe_deframer_core_assert.svh
// Assertion macros for the audio super-frame deframer.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef AAC_SUPERFRAME_DEFRAMER_CORE_ASSERT_SVH
`define AAC_SUPERFRAME_DEFRAMER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define AAC_SFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aac_sfd: same-cycle check failed");
`define AAC_SFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aac_sfd: next-cycle check failed");
`else
`define AAC_SFD_ASSERT_NOW(label, ante, cons)
`define AAC_SFD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/aac_sfd_pkg.sv
// Shared types, constants and helper functions of the audio super-frame deframer.
// No dependencies; used by every module of the block.
package aac_sfd_pkg;

    localparam int MAX_FRAMES  = 10;
    localparam int BORDER_BITS = 12;
    localparam int BYTE_W      = 8;
    localparam int FRAME_W     = 4;
    localparam int POS_W       = 12;
    localparam int LEN_W       = 12;
    localparam int WIDE_W      = (BORDER_BITS > LEN_W) ? BORDER_BITS : LEN_W;
    localparam int HC_W        = 4;
    localparam int CB_W        = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int MAX_RESULTS = 3;
    localparam int RCOUNT_W    = 2;

    localparam int BORDERS_12K = (4 > MAX_FRAMES - 1) ? MAX_FRAMES - 1 : 4;
    localparam int BORDERS_24K = (9 > MAX_FRAMES - 1) ? MAX_FRAMES - 1 : 9;
    localparam int HDR_BYTES_12K = (BORDERS_12K * BORDER_BITS + 7) / 8;
    localparam int HDR_BYTES_24K = (BORDERS_24K * BORDER_BITS + 7) / 8;
    localparam int HC_MAX = (1 << HC_W) - 1;

    typedef enum logic [1:0] {
        KIND_LENGTH  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_MODE   = 2'd0,
        CFG_PAYLOAD_LEN = 2'd1,
        CFG_HIGHER_LEN  = 2'd2
    } t_cfg_index;

    typedef struct packed {
        t_kind               kind;
        logic [FRAME_W-1:0]  frame_number;
        logic [POS_W-1:0]    position;
        logic [BYTE_W-1:0]   data_byte;
        logic                header_good;
        logic                end_of_frame;
        logic                end_of_superframe;
    } t_result;

    typedef struct packed {
        t_result [MAX_RESULTS-1:0] slot;
        logic [RCOUNT_W-1:0]       count;
    } t_bundle;

    function automatic logic [LEN_W-1:0] clamp_len(
        logic [WIDE_W-1:0] d,
        logic [LEN_W-1:0]  hl,
        logic [LEN_W-1:0]  pl
    );
        logic [LEN_W-1:0] res;
        if (d < WIDE_W'(hl)) begin
            res = hl;
        end else if (d > WIDE_W'(pl)) begin
            res = pl;
        end else begin
            res = LEN_W'(d);
        end
        return res;
    endfunction

    function automatic logic [FRAME_W-1:0] next_frame(
        logic [MAX_FRAMES-1:0] has_lower,
        logic [FRAME_W-1:0]    start,
        logic [FRAME_W-1:0]    last
    );
        logic [FRAME_W-1:0] res;
        logic [FRAME_W-1:0] stop;
        stop = last + FRAME_W'(1);
        res  = (start > stop) ? start : stop;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if (has_lower[i] && FRAME_W'(i) >= start && FRAME_W'(i) <= last) begin
                res = FRAME_W'(i);
            end
        end
        return res;
    endfunction

endpackage

### design/aac_sfd_parser.sv
// Header parser and payload splitter: holds the configuration and the stream state
// and turns one accepted byte into a bundle of up to three results. Uses aac_sfd_pkg.
module aac_sfd_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [aac_sfd_pkg::BYTE_W-1:0]      i_stream_byte,
    input  logic                                i_frame_start,
    input  logic                                i_cfg_write,
    input  logic [aac_sfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [aac_sfd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output aac_sfd_pkg::t_bundle                o_bundle
);

    localparam int BW    = aac_sfd_pkg::BORDER_BITS;
    localparam int FW    = aac_sfd_pkg::FRAME_W;
    localparam int LW    = aac_sfd_pkg::LEN_W;
    localparam int CW    = aac_sfd_pkg::CB_W;
    localparam int HW    = aac_sfd_pkg::HC_W;
    localparam int CAT_W = BW + aac_sfd_pkg::BYTE_W;
    localparam int NF    = aac_sfd_pkg::MAX_FRAMES;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    function automatic logic [CAT_W-1:0] low_mask(logic [CW:0] bits);
        return (CAT_W'(1) << bits) - CAT_W'(1);
    endfunction

    function automatic logic [aac_sfd_pkg::WIDE_W-1:0] WIDE_W_EXT(logic [LW-1:0] v);
        return aac_sfd_pkg::WIDE_W'(v);
    endfunction

    logic          r_rate_mode;
    logic [LW-1:0] r_payload_len;
    logic [LW-1:0] r_higher_len;

    t_phase        r_phase, n_phase, e_phase;
    logic [HW-1:0] r_hc, n_hc, e_hc;
    logic [BW-1:0] r_carry, n_carry, e_carry;
    logic [CW-1:0] r_cb, n_cb, e_cb;
    logic [BW-1:0] r_prev, n_prev, e_prev;
    logic [FW-1:0] r_bn, n_bn, e_bn;
    logic          r_bad, n_bad, e_bad;
    logic [FW-1:0] r_cf, n_cf, e_cf;
    logic [LW-1:0] r_bc, n_bc, e_bc;
    logic [LW-1:0] r_len [NF];
    logic [LW-1:0] n_len [NF];

    logic [FW-1:0]    nb;
    logic [7:0]       hbytes;
    logic [CW:0]      bits;
    logic [CW:0]      rem;
    logic [CAT_W-1:0] cat;
    logic [CAT_W-1:0] rest;
    logic [BW-1:0]    border;
    logic             hit;
    logic             fin;
    logic [LW-1:0]    blen;
    logic [LW-1:0]    llen;
    logic [LW-1:0]    cur_len;
    logic [LW-1:0]    cnt;
    logic [LW:0]      bc_inc;
    logic [NF-1:0]    has_lower;
    logic             eof;
    logic             eos;
    aac_sfd_pkg::t_result res_border, res_last, res_status, res_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_mode   <= 1'b0;
            r_payload_len <= '0;
            r_higher_len  <= '0;
        end else if (i_cfg_write) begin
            case (i_cfg_index)
                aac_sfd_pkg::CFG_RATE_MODE:   r_rate_mode   <= i_cfg_data[0];
                aac_sfd_pkg::CFG_PAYLOAD_LEN: r_payload_len <= LW'(i_cfg_data);
                aac_sfd_pkg::CFG_HIGHER_LEN:  r_higher_len  <= LW'(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        if (i_frame_start) begin
            e_phase = PH_HEADER;
            e_hc    = '0;
            e_carry = '0;
            e_cb    = '0;
            e_prev  = '0;
            e_bn    = '0;
            e_bad   = 1'b0;
            e_cf    = '0;
            e_bc    = '0;
        end else begin
            e_phase = r_phase;
            e_hc    = r_hc;
            e_carry = r_carry;
            e_cb    = r_cb;
            e_prev  = r_prev;
            e_bn    = r_bn;
            e_bad   = r_bad;
            e_cf    = r_cf;
            e_bc    = r_bc;
        end

        n_phase = e_phase;
        n_hc    = e_hc;
        n_carry = e_carry;
        n_cb    = e_cb;
        n_prev  = e_prev;
        n_bn    = e_bn;
        n_bad   = e_bad;
        n_cf    = e_cf;
        n_bc    = e_bc;
        n_len   = r_len;

        nb     = r_rate_mode ? FW'(aac_sfd_pkg::BORDERS_24K) : FW'(aac_sfd_pkg::BORDERS_12K);
        hbytes = r_rate_mode ? 8'(aac_sfd_pkg::HDR_BYTES_24K) : 8'(aac_sfd_pkg::HDR_BYTES_12K);
        bits      = '0;
        rem       = '0;
        cat       = '0;
        rest      = '0;
        border    = '0;
        hit       = 1'b0;
        fin       = 1'b0;
        blen      = '0;
        llen      = '0;
        cur_len   = '0;
        cnt       = '0;
        bc_inc    = '0;
        has_lower = '0;
        eof       = 1'b0;
        eos       = 1'b0;
        res_border = '0;
        res_last   = '0;
        res_status = '0;
        res_pay    = '0;
        o_bundle   = '0;

        case (e_phase)
            PH_HEADER: begin
                n_hc = (e_hc < HW'(aac_sfd_pkg::HC_MAX)) ? e_hc + HW'(1) : e_hc;
                if (e_bn >= nb) begin
                    n_carry = '0;
                    n_cb    = '0;
                end else begin
                    bits = {1'b0, e_cb} + (CW + 1)'(aac_sfd_pkg::BYTE_W);
                    cat  = {e_carry, i_stream_byte} & low_mask(bits);
                    rem  = bits;
                    rest = cat;
                    if (bits >= (CW + 1)'(BW)) begin
                        hit    = 1'b1;
                        rem    = bits - (CW + 1)'(BW);
                        border = BW'(cat >> rem);
                        rest   = cat & low_mask(rem);
                    end
                    n_carry = BW'(rest);
                    n_cb    = CW'(rem);
                    if (hit) begin
                        if (border >= e_prev) begin
                            blen = aac_sfd_pkg::clamp_len(WIDE_W_EXT(border) - WIDE_W_EXT(e_prev),
                                                          r_higher_len, r_payload_len);
                        end else begin
                            n_bad = 1'b1;
                        end
                        n_len[e_bn] = blen;
                        res_border.kind         = aac_sfd_pkg::KIND_LENGTH;
                        res_border.frame_number = e_bn;
                        res_border.position     = aac_sfd_pkg::POS_W'(blen);
                        res_border.header_good  = !n_bad;
                        n_prev = border;
                        n_bn   = e_bn + FW'(1);
                    end
                end
                if (8'(n_hc) >= hbytes) begin
                    fin = 1'b1;
                    if (WIDE_W_EXT(r_payload_len) >= WIDE_W_EXT(n_prev)) begin
                        llen = aac_sfd_pkg::clamp_len(
                            WIDE_W_EXT(r_payload_len) - WIDE_W_EXT(n_prev),
                            r_higher_len, r_payload_len);
                    end else begin
                        n_bad = 1'b1;
                    end
                    n_len[n_bn] = llen;
                    res_last.kind         = aac_sfd_pkg::KIND_LENGTH;
                    res_last.frame_number = n_bn;
                    res_last.position     = aac_sfd_pkg::POS_W'(llen);
                    res_last.header_good  = !n_bad;
                    res_status.kind        = aac_sfd_pkg::KIND_STATUS;
                    res_status.position    = aac_sfd_pkg::POS_W'(n_bn)
                                             + aac_sfd_pkg::POS_W'(1);
                    res_status.header_good = !n_bad;
                    n_carry = '0;
                    n_cb    = '0;
                    n_bc    = '0;
                    n_phase = PH_IDLE;
                    for (int i = 0; i < NF; i++) begin
                        has_lower[i] = n_len[i] > r_higher_len;
                    end
                    if (!n_bad) begin
                        n_cf = aac_sfd_pkg::next_frame(has_lower, '0, n_bn);
                        if (n_cf <= n_bn) begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                if (hit && fin) begin
                    o_bundle.slot[0] = res_border;
                    o_bundle.slot[1] = res_last;
                    o_bundle.slot[2] = res_status;
                    o_bundle.count   = aac_sfd_pkg::RCOUNT_W'(3);
                end else if (fin) begin
                    o_bundle.slot[0] = res_last;
                    o_bundle.slot[1] = res_status;
                    o_bundle.count   = aac_sfd_pkg::RCOUNT_W'(2);
                end else if (hit) begin
                    o_bundle.slot[0] = res_border;
                    o_bundle.count   = aac_sfd_pkg::RCOUNT_W'(1);
                end
            end
            PH_PAYLOAD: begin
                for (int i = 0; i < NF; i++) begin
                    has_lower[i] = r_len[i] > r_higher_len;
                end
                cur_len = r_len[e_cf];
                cnt     = (cur_len > r_higher_len) ? cur_len - r_higher_len : '0;
                bc_inc  = {1'b0, e_bc} + (LW + 1)'(1);
                n_bc    = LW'(bc_inc);
                if (bc_inc >= {1'b0, cnt}) begin
                    eof  = 1'b1;
                    n_bc = '0;
                    n_cf = aac_sfd_pkg::next_frame(has_lower, e_cf + FW'(1), e_bn);
                    if (n_cf > e_bn) begin
                        eos     = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
                res_pay.kind              = aac_sfd_pkg::KIND_PAYLOAD;
                res_pay.frame_number      = e_cf;
                res_pay.position          = aac_sfd_pkg::POS_W'(r_higher_len + e_bc);
                res_pay.data_byte         = i_stream_byte;
                res_pay.header_good       = 1'b1;
                res_pay.end_of_frame      = eof;
                res_pay.end_of_superframe = eos;
                o_bundle.slot[0] = res_pay;
                o_bundle.count   = aac_sfd_pkg::RCOUNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_hc    <= '0;
            r_carry <= '0;
            r_cb    <= '0;
            r_prev  <= '0;
            r_bn    <= '0;
            r_bad   <= 1'b0;
            r_cf    <= '0;
            r_bc    <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_hc    <= n_hc;
            r_carry <= n_carry;
            r_cb    <= n_cb;
            r_prev  <= n_prev;
            r_bn    <= n_bn;
            r_bad   <= n_bad;
            r_cf    <= n_cf;
            r_bc    <= n_bc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_len <= n_len;
        end
    end

endmodule

### design/aac_sfd_outq.sv
// Result register of the deframer: holds the bundle of one byte and hands its
// results out one transfer at a time. Uses aac_sfd_pkg.
module aac_sfd_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  aac_sfd_pkg::t_bundle  i_bundle,
    input  logic                  i_out_stall,
    output logic                  o_load_ok,
    output logic                  o_valid,
    output aac_sfd_pkg::t_result  o_head
);

    localparam int NR = aac_sfd_pkg::MAX_RESULTS;
    localparam int CW = aac_sfd_pkg::RCOUNT_W;

    aac_sfd_pkg::t_result [NR-1:0] r_slot;
    logic [CW-1:0]                 r_count;
    logic                          take;

    assign o_valid   = r_count != '0;
    assign o_head    = r_slot[0];
    assign take      = o_valid && !i_out_stall;
    assign o_load_ok = (r_count == '0) || (r_count == CW'(1) && take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_load) begin
            r_count <= i_bundle.count;
        end else if (take) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_bundle.slot;
        end else if (take) begin
            for (int i = 0; i < NR - 1; i++) begin
                r_slot[i] <= r_slot[i + 1];
            end
            r_slot[NR-1] <= '0;
        end
    end

endmodule

### design/aac_superframe_deframer_core.sv
// Top level of the audio super-frame deframer: parser plus result register.
// Uses aac_sfd_pkg, aac_sfd_parser, aac_sfd_outq and the assertion macro header.
//
// The block takes one byte per cycle when not stalled. A header byte that completes a
// border gives one length result; the last header byte gives up to three (last border,
// last length, status); these leave the three-entry result register one per cycle
// while i_out_stall is low, and the input is stalled until the last is taken. Every
// payload byte gives one result and the next byte is taken in the same cycle as that
// result's transfer: a steady payload runs at one byte per cycle when unstalled. The
// parser is combinational up to the result register; configuration writes are
// taken at any time and are meant to happen while no results are pending.
`include "aac_superframe_deframer_core_assert.svh"

module aac_superframe_deframer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [aac_sfd_pkg::BYTE_W-1:0]      i_stream_byte,
    input  logic                                i_frame_start,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_kind,
    output logic [aac_sfd_pkg::FRAME_W-1:0]     o_frame_number,
    output logic [aac_sfd_pkg::POS_W-1:0]       o_position,
    output logic [aac_sfd_pkg::BYTE_W-1:0]      o_data_byte,
    output logic                                o_header_good,
    output logic                                o_end_of_frame,
    output logic                                o_end_of_superframe,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [aac_sfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [aac_sfd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    aac_sfd_pkg::t_bundle w_bundle;
    aac_sfd_pkg::t_result w_head;
    logic                 w_load_ok;
    logic                 w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !w_load_ok;
    assign w_accept    = i_in_valid && w_load_ok;

    aac_sfd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_stream_byte (i_stream_byte),
        .i_frame_start (i_frame_start),
        .i_cfg_write   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_bundle      (w_bundle)
    );

    aac_sfd_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept),
        .i_bundle    (w_bundle),
        .i_out_stall (i_out_stall),
        .o_load_ok   (w_load_ok),
        .o_valid     (o_out_valid),
        .o_head      (w_head)
    );

    assign o_kind              = w_head.kind;
    assign o_frame_number      = w_head.frame_number;
    assign o_position          = w_head.position;
    assign o_data_byte         = w_head.data_byte;
    assign o_header_good       = w_head.header_good;
    assign o_end_of_frame      = w_head.end_of_frame;
    assign o_end_of_superframe = w_head.end_of_superframe;

    `AAC_SFD_ASSERT_NEXT(a_triple_leads_with_length, w_accept && w_bundle.count == 2'd3, o_out_valid && o_kind == aac_sfd_pkg::KIND_LENGTH)
    `AAC_SFD_ASSERT_NEXT(a_empty_load_leaves_idle, w_accept && w_bundle.count == 2'd0, !o_out_valid)
    `AAC_SFD_ASSERT_NOW(a_payload_only_after_good, o_out_valid && o_kind == aac_sfd_pkg::KIND_PAYLOAD, o_header_good)
    `AAC_SFD_ASSERT_NOW(a_superframe_end_ends_frame, o_out_valid && o_end_of_superframe, o_end_of_frame && o_kind == aac_sfd_pkg::KIND_PAYLOAD)

endmodule
